// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define LRS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- sv/lrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Link reconnect supervisor package
// Event codes, register map, reset values, shared types and the backoff function.
// ----------------------------------------------------------------------------
package lrs_pkg;

   localparam logic [2:0] OP_START      = 3'd0;
   localparam logic [2:0] OP_STOP       = 3'd1;
   localparam logic [2:0] OP_CONNECTED  = 3'd2;
   localparam logic [2:0] OP_CORRECTION = 3'd3;
   localparam logic [2:0] OP_FAILURE    = 3'd4;
   localparam logic [2:0] OP_RETRY      = 3'd5;

   localparam logic [1:0] CSR_IDX_GAP    = 2'd0;
   localparam logic [1:0] CSR_IDX_PERIOD = 2'd1;
   localparam logic [1:0] CSR_IDX_MAXF   = 2'd2;

   localparam logic [19:0] GAP_RESET    = 20'd5000;
   localparam logic [21:0] PERIOD_RESET = 22'd30000;
   localparam logic [7:0]  MAXF_RESET   = 8'd10;

   localparam logic [18:0] BACKOFF_BASE_MS   = 19'd1000;
   localparam logic [2:0]  BACKOFF_MAX_SHIFT = 3'd5;
   localparam logic [18:0] BACKOFF_CAP_MS    = 19'd30000;
   localparam logic [18:0] RETRY_CAP_MS      = 19'd300000;
   localparam logic [7:0]  FAIL_SAT          = 8'd255;

   typedef struct packed {
      logic [19:0] gap_limit_ms;
      logic [21:0] window_len_ms;
      logic [7:0]  max_failures;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic        reconnect_enable;
      logic        settings_valid;
      logic        stream_ready;
      logic        retryable;
      logic [18:0] retry_after_ms;
      logic        rx_fresh;
   } event_type;

   typedef struct packed {
      logic [2:0]  session_state;
      logic        retry_request;
      logic [18:0] retry_delay_ms;
      logic [7:0]  failure_count;
      logic        stream_launch;
   } result_type;

   function automatic logic [18:0] backoff_ms(input logic [7:0] fails);
      logic [7:0]  n;
      logic [2:0]  shift;
      logic [18:0] d;
      n = (fails == 8'd0) ? 8'd0 : fails - 8'd1;
      shift = (n > 8'(BACKOFF_MAX_SHIFT)) ? BACKOFF_MAX_SHIFT : n[2:0];
      d = BACKOFF_BASE_MS << shift;
      return (d > BACKOFF_CAP_MS) ? BACKOFF_CAP_MS : d;
   endfunction

endpackage

// ----- sv/lrs_session.sv -----
// ----------------------------------------------------------------------------
// Link reconnect supervisor session engine
// Holds the session state and health window and registers one result per beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrs_session
   import lrs_pkg::*;
#(
   parameter int TIME_BITS = 47
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  event_type            ev,
   input  logic [TIME_BITS-1:0] rx_ms,
   input  cfg_type              cfg,
   output result_type           result
);

   typedef enum logic [2:0] {
      MODE_DISCONNECTED = 3'd0,
      MODE_CONNECTING   = 3'd1,
      MODE_CONNECTED    = 3'd2,
      MODE_RECONNECTING = 3'd3,
      MODE_ERROR        = 3'd4
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic                 auto_ff, auto_in;
   logic [7:0]           failures_ff, failures_in;
   logic [TIME_BITS-1:0] health_start_ff, health_start_in;
   logic [TIME_BITS-1:0] last_good_ff, last_good_in;
   logic                 health_open_ff, health_open_in;
   result_type           result_ff, result_in;

   logic                 open_new;
   logic                 period_hit;
   logic [7:0]           fails_inc;
   logic [18:0]          delay_raw;
   logic [18:0]          delay_min;

   always_comb begin
      open_new = !health_open_ff
         || (rx_ms >= last_good_ff
             && (rx_ms - last_good_ff) > TIME_BITS'(cfg.gap_limit_ms));
      period_hit = open_new ? (cfg.window_len_ms == 22'd0)
         : (rx_ms >= health_start_ff
            && (rx_ms - health_start_ff) >= TIME_BITS'(cfg.window_len_ms));
      fails_inc = (failures_ff == FAIL_SAT) ? FAIL_SAT : failures_ff + 8'd1;
      delay_raw = backoff_ms(fails_inc);
      delay_min = (ev.retry_after_ms > delay_raw) ? ev.retry_after_ms : delay_raw;

      mode_in         = mode_ff;
      auto_in         = auto_ff;
      failures_in     = failures_ff;
      health_start_in = health_start_ff;
      last_good_in    = last_good_ff;
      health_open_in  = health_open_ff;
      result_in       = '0;

      unique case (ev.opcode)
         OP_START: begin
            auto_in         = ev.reconnect_enable;
            failures_in     = 8'd0;
            health_open_in  = 1'b0;
            health_start_in = '0;
            last_good_in    = '0;
            if (ev.settings_valid && ev.stream_ready) begin
               mode_in                = MODE_CONNECTING;
               result_in.stream_launch = 1'b1;
            end else begin
               mode_in = MODE_ERROR;
            end
         end
         OP_STOP: begin
            failures_in     = 8'd0;
            health_open_in  = 1'b0;
            health_start_in = '0;
            last_good_in    = '0;
            mode_in         = MODE_DISCONNECTED;
         end
         OP_CONNECTED: begin
            if (mode_ff == MODE_CONNECTING) begin
               mode_in = MODE_CONNECTED;
            end
         end
         OP_CORRECTION: begin
            if (mode_ff == MODE_CONNECTING || mode_ff == MODE_CONNECTED) begin
               mode_in = MODE_CONNECTED;
               if (ev.rx_fresh) begin
                  if (open_new) begin
                     health_start_in = rx_ms;
                  end
                  health_open_in = 1'b1;
                  last_good_in   = rx_ms;
                  if (period_hit) begin
                     failures_in = 8'd0;
                  end
               end
            end
         end
         OP_FAILURE: begin
            if (mode_ff == MODE_CONNECTING || mode_ff == MODE_CONNECTED) begin
               failures_in     = fails_inc;
               health_open_in  = 1'b0;
               health_start_in = '0;
               last_good_in    = '0;
               if (!auto_ff || !ev.retryable || fails_inc >= cfg.max_failures) begin
                  mode_in = MODE_ERROR;
               end else begin
                  mode_in                  = MODE_RECONNECTING;
                  result_in.retry_request  = 1'b1;
                  result_in.retry_delay_ms =
                     (delay_min > RETRY_CAP_MS) ? RETRY_CAP_MS : delay_min;
               end
            end
         end
         OP_RETRY: begin
            if (mode_ff == MODE_RECONNECTING) begin
               if (ev.stream_ready) begin
                  mode_in                 = MODE_CONNECTING;
                  result_in.stream_launch = 1'b1;
               end else begin
                  mode_in = MODE_ERROR;
               end
            end
         end
         default: begin
         end
      endcase

      result_in.session_state = mode_in;
      result_in.failure_count = failures_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_DISCONNECTED;
         auto_ff         <= 1'b0;
         failures_ff     <= 8'd0;
         health_start_ff <= '0;
         last_good_ff    <= '0;
         health_open_ff  <= 1'b0;
         result_ff       <= '0;
      end else if (fire) begin
         mode_ff         <= mode_in;
         auto_ff         <= auto_in;
         failures_ff     <= failures_in;
         health_start_ff <= health_start_in;
         last_good_ff    <= last_good_in;
         health_open_ff  <= health_open_in;
         result_ff       <= result_in;
      end
   end

   assign result = result_ff;

   `LRS_ASSERT(a_retry_in_reconnecting, clock, reset,
      !result_ff.retry_request || (result_ff.session_state == MODE_RECONNECTING
         && result_ff.retry_delay_ms >= BACKOFF_BASE_MS
         && result_ff.retry_delay_ms <= RETRY_CAP_MS),
      "retry request outside reconnecting or delay out of range")
   `LRS_ASSERT(a_no_delay_without_retry, clock, reset,
      result_ff.retry_request || result_ff.retry_delay_ms == 19'd0,
      "retry delay given without a retry request")
   `LRS_ASSERT(a_launch_connecting, clock, reset,
      !result_ff.stream_launch || result_ff.session_state == MODE_CONNECTING,
      "stream launch outside connecting")
   `LRS_ASSERT_NEXT(a_stop_clears, clock, reset, fire && ev.opcode == OP_STOP,
      mode_ff == MODE_DISCONNECTED && failures_ff == 8'd0 && !health_open_ff,
      "stop did not clear the session")

endmodule

// ----- sv/link_reconnect_supervisor_top.sv -----
// ----------------------------------------------------------------------------
// Link reconnect supervisor
// Session supervisor for a correction-data link with exponential retry backoff.
// ----------------------------------------------------------------------------
// The req_ channel carries one event per beat: start, stop, connected,
// correction, failure or retry expired, with its time stamps and flags.
// The rsp_ channel returns exactly one result beat for every event beat,
// in order: session state, retry request and delay, failure count and
// stream launch. Both channels use valid and stall.
// An event is captured in an input register, where its correction age is
// checked against the gap register; once the result register can take it,
// the session engine evaluates it and writes the result register. rsp_valid
// is registered alongside the result register. One event is taken in every
// cycle while rsp_stall holds no waiting result.
// When rsp_stall holds a waiting result, the engine stops, one further event
// can still sit in the input register, and req_stall rises only then.
// Reset is synchronous: it empties both registers, returns the session to
// disconnected with no failures and a closed window, and loads the register
// defaults. The csr_ port writes the gap, period and failure limit and should
// be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module link_reconnect_supervisor_top
   import lrs_pkg::*;
#(
   parameter int TIME_BITS = 47
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_opcode,
   input  logic [TIME_BITS-1:0] req_now_ms,
   input  logic [TIME_BITS-1:0] req_received_at_ms,
   input  logic                 req_reconnect_enable,
   input  logic                 req_settings_valid,
   input  logic                 req_stream_ready,
   input  logic                 req_retryable,
   input  logic [18:0]          req_retry_after_ms,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_session_state,
   output logic                 rsp_retry_request,
   output logic [18:0]          rsp_retry_delay_ms,
   output logic [7:0]           rsp_failure_count,
   output logic                 rsp_stream_launch,

   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   cfg_type              cfg_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   event_type            ev_ff, ev_in;
   logic [TIME_BITS-1:0] rx_ff;
   logic                 req_accept;
   logic                 fire;
   logic                 csr_write;
   result_type           result;

   assign fire       = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !fire);
      out_valid_in = fire || (out_valid_ff && rsp_stall);

      ev_in.opcode           = req_opcode;
      ev_in.reconnect_enable = req_reconnect_enable;
      ev_in.settings_valid   = req_settings_valid;
      ev_in.stream_ready     = req_stream_ready;
      ev_in.retryable        = req_retryable;
      ev_in.retry_after_ms   = req_retry_after_ms;
      ev_in.rx_fresh         = (req_received_at_ms != '0)
         && (req_received_at_ms <= req_now_ms)
         && ((req_now_ms - req_received_at_ms) <= TIME_BITS'(cfg_ff.gap_limit_ms));
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_IDX_GAP:    csr_prdata = 32'(cfg_ff.gap_limit_ms);
         CSR_IDX_PERIOD: csr_prdata = 32'(cfg_ff.window_len_ms);
         CSR_IDX_MAXF:   csr_prdata = 32'(cfg_ff.max_failures);
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         cfg_ff.gap_limit_ms  <= GAP_RESET;
         cfg_ff.window_len_ms <= PERIOD_RESET;
         cfg_ff.max_failures  <= MAXF_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            unique case (csr_paddr[3:2])
               CSR_IDX_GAP:    cfg_ff.gap_limit_ms  <= csr_pwdata[19:0];
               CSR_IDX_PERIOD: cfg_ff.window_len_ms <= csr_pwdata[21:0];
               CSR_IDX_MAXF:   cfg_ff.max_failures  <= csr_pwdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ev_ff <= ev_in;
         rx_ff <= req_received_at_ms;
      end
   end

   lrs_session #(
      .TIME_BITS (TIME_BITS)
   ) u_session (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .ev     (ev_ff),
      .rx_ms  (rx_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_session_state  = result.session_state;
   assign rsp_retry_request  = result.retry_request;
   assign rsp_retry_delay_ms = result.retry_delay_ms;
   assign rsp_failure_count  = result.failure_count;
   assign rsp_stream_launch  = result.stream_launch;

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Link reconnect supervisor testbench
// Drives event beats into the supervisor with random gaps and result stalls,
// predicts every result beat from its own session tracker and compares them
// field by field. The run steps through several register settings, the
// extremes among them, and checks each register by reading it back.
// ----------------------------------------------------------------------------
module tb
   import lrs_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 900000;
   localparam int unsigned DRAIN_LIMIT = 2000;
   localparam int unsigned PRINT_LIMIT = 40;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef enum logic [2:0] {
      ST_DISCONNECTED = 3'd0,
      ST_CONNECTING   = 3'd1,
      ST_CONNECTED    = 3'd2,
      ST_RECONNECTING = 3'd3,
      ST_ERROR        = 3'd4
   } session_state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [46:0] now_ms;
      logic [46:0] rx_ms;
      logic        recon;
      logic        settings_ok;
      logic        ready;
      logic        retryable;
      logic [18:0] after_ms;
   } link_event_type;

   class session_tracker_type;
      logic [19:0]       gap_ms;
      logic [21:0]       period_ms;
      logic [7:0]        fail_limit;
      session_state_type mode;
      logic              auto_recon;
      logic [7:0]        fails;
      logic [46:0]       win_start;
      logic [46:0]       last_good;
      logic              win_open;
      result_type        awaited_results[$];
      int unsigned       checked, launches, retry_requests, health_clears;

      function new();
         gap_ms = GAP_RESET;
         period_ms = PERIOD_RESET;
         fail_limit = MAXF_RESET;
         mode = ST_DISCONNECTED;
         auto_recon = 1'b0;
         fails = '0;
         close_window();
      endfunction

      function void close_window();
         win_open = 1'b0;
         win_start = '0;
         last_good = '0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_IDX_GAP: begin
               gap_ms = value[19:0];
            end
            CSR_IDX_PERIOD: begin
               period_ms = value[21:0];
            end
            CSR_IDX_MAXF: begin
               fail_limit = value[7:0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [18:0] backoff_delay();
         int unsigned steps;
         int unsigned d;
         steps = (fails == 8'd0) ? 0 : int'(fails) - 1;
         if (steps > BACKOFF_MAX_SHIFT)
            steps = 32'(BACKOFF_MAX_SHIFT);
         d = 32'(BACKOFF_BASE_MS) << steps;
         if (d > BACKOFF_CAP_MS)
            d = 32'(BACKOFF_CAP_MS);
         return d[18:0];
      endfunction

      function void take_correction(logic [46:0] now, logic [46:0] rx);
         if (rx == '0 || rx > now || now - rx > gap_ms)
            return;
         if (!win_open || (rx >= last_good && rx - last_good > gap_ms)) begin
            win_start = rx;
            win_open = 1'b1;
         end
         last_good = rx;
         if (rx >= win_start && rx - win_start >= period_ms) begin
            if (fails != 8'd0)
               health_clears++;
            fails = '0;
         end
      endfunction

      function void note_event(link_event_type b);
         result_type  r;
         int unsigned d;
         r = '0;
         case (b.opcode)
            OP_START: begin
               auto_recon = b.recon;
               fails = '0;
               close_window();
               if (!b.settings_ok || !b.ready) begin
                  mode = ST_ERROR;
               end else begin
                  mode = ST_CONNECTING;
                  r.stream_launch = 1'b1;
               end
            end
            OP_STOP: begin
               fails = '0;
               close_window();
               mode = ST_DISCONNECTED;
            end
            OP_CONNECTED: begin
               if (mode == ST_CONNECTING)
                  mode = ST_CONNECTED;
            end
            OP_CORRECTION: begin
               if (mode == ST_CONNECTING)
                  mode = ST_CONNECTED;
               if (mode == ST_CONNECTED)
                  take_correction(b.now_ms, b.rx_ms);
            end
            OP_FAILURE: begin
               if (mode == ST_CONNECTING || mode == ST_CONNECTED) begin
                  if (fails != FAIL_SAT)
                     fails++;
                  close_window();
                  if (!auto_recon || !b.retryable || fails >= fail_limit) begin
                     mode = ST_ERROR;
                  end else begin
                     d = 32'(backoff_delay());
                     if (b.after_ms > d)
                        d = 32'(b.after_ms);
                     if (d > RETRY_CAP_MS)
                        d = 32'(RETRY_CAP_MS);
                     mode = ST_RECONNECTING;
                     r.retry_request = 1'b1;
                     r.retry_delay_ms = d[18:0];
                  end
               end
            end
            OP_RETRY: begin
               if (mode == ST_RECONNECTING) begin
                  if (b.ready) begin
                     mode = ST_CONNECTING;
                     r.stream_launch = 1'b1;
                  end else begin
                     mode = ST_ERROR;
                  end
               end
            end
            default: begin
            end
         endcase
         r.session_state = mode;
         r.failure_count = fails;
         if (r.stream_launch)
            launches++;
         if (r.retry_request)
            retry_requests++;
         awaited_results.push_back(r);
      endfunction

      function string check_result(result_type got);
         result_type want;
         string      msg;
         if (awaited_results.size() == 0)
            return "result beat with no event outstanding";
         want = awaited_results.pop_front();
         checked++;
         msg = "";
         if (got.session_state !== want.session_state)
            msg = {msg, $sformatf(" state %0d/%0d", got.session_state, want.session_state)};
         if (got.retry_request !== want.retry_request)
            msg = {msg, $sformatf(" retry_req %0b/%0b", got.retry_request, want.retry_request)};
         if (got.retry_delay_ms !== want.retry_delay_ms)
            msg = {msg, $sformatf(" delay %0d/%0d", got.retry_delay_ms, want.retry_delay_ms)};
         if (got.failure_count !== want.failure_count)
            msg = {msg, $sformatf(" fails %0d/%0d", got.failure_count, want.failure_count)};
         if (got.stream_launch !== want.stream_launch)
            msg = {msg, $sformatf(" launch %0b/%0b", got.stream_launch, want.stream_launch)};
         if (msg != "")
            msg = {$sformatf("result %0d (got/expected):", checked), msg};
         return msg;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [46:0] req_now_ms;
   logic [46:0] req_received_at_ms;
   logic        req_reconnect_enable;
   logic        req_settings_valid;
   logic        req_stream_ready;
   logic        req_retryable;
   logic [18:0] req_retry_after_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_session_state;
   logic        rsp_retry_request;
   logic [18:0] rsp_retry_delay_ms;
   logic [7:0]  rsp_failure_count;
   logic        rsp_stream_launch;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   session_tracker_type tracker;
   int unsigned         mismatches;
   int unsigned         cycle_count;
   int unsigned         beats_sent;
   int unsigned         settings_used;
   int unsigned         req_gap_pct;
   int unsigned         rsp_stall_pct;
   int unsigned         stall_left;
   logic [46:0]         wall_ms;
   logic [46:0]         last_rx;
   result_type          seen_result;
   string               verdict;

   link_reconnect_supervisor_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_now_ms           (req_now_ms),
      .req_received_at_ms   (req_received_at_ms),
      .req_reconnect_enable (req_reconnect_enable),
      .req_settings_valid   (req_settings_valid),
      .req_stream_ready     (req_stream_ready),
      .req_retryable        (req_retryable),
      .req_retry_after_ms   (req_retry_after_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_session_state    (rsp_session_state),
      .rsp_retry_request    (rsp_retry_request),
      .rsp_retry_delay_ms   (rsp_retry_delay_ms),
      .rsp_failure_count    (rsp_failure_count),
      .rsp_stream_launch    (rsp_stream_launch),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      if (mismatches < PRINT_LIMIT)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, tracker.awaited_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.session_state = rsp_session_state;
         seen_result.retry_request = rsp_retry_request;
         seen_result.retry_delay_ms = rsp_retry_delay_ms;
         seen_result.failure_count = rsp_failure_count;
         seen_result.stream_launch = rsp_stream_launch;
         verdict = tracker.check_result(seen_result);
         if (verdict != "")
            report_mismatch(verdict);
      end
   end

   function automatic bit chance(int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic int unsigned pick_len(int unsigned pct, int unsigned longest);
      if (!chance(pct))
         return 0;
      if (chance(85))
         return $urandom_range(1, 3);
      return $urandom_range(10, longest);
   endfunction

   function automatic logic [46:0] rand_time();
      return {15'($urandom), 32'($urandom)};
   endfunction

   initial begin
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else begin
            stall_left = pick_len(rsp_stall_pct, 60);
            if (stall_left != 0) begin
               stall_left--;
               rsp_stall = 1'b1;
            end else begin
               rsp_stall = 1'b0;
            end
         end
      end
   end

   task automatic drive_beat(link_event_type b);
      int unsigned gap;
      gap = pick_len(req_gap_pct, 40);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode = b.opcode;
      req_now_ms = b.now_ms;
      req_received_at_ms = b.rx_ms;
      req_reconnect_enable = b.recon;
      req_settings_valid = b.settings_ok;
      req_stream_ready = b.ready;
      req_retryable = b.retryable;
      req_retry_after_ms = b.after_ms;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_event(b);
      beats_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] readback;
      case (idx)
         CSR_IDX_GAP:    mask = 32'h000F_FFFF;
         CSR_IDX_PERIOD: mask = 32'h003F_FFFF;
         CSR_IDX_MAXF:   mask = 32'h0000_00FF;
         default:        mask = '0;
      endcase
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if ((readback & mask) !== (value & mask))
         report_mismatch($sformatf("register %0d reads 0x%0h, wrote 0x%0h",
                                   idx, readback, value));
   endtask

   task automatic apply_settings(logic [31:0] gap, logic [31:0] period, logic [31:0] limit,
                                 int unsigned gap_pct, int unsigned stall_pct);
      settle();
      write_register(CSR_IDX_GAP, gap);
      write_register(CSR_IDX_PERIOD, period);
      write_register(CSR_IDX_MAXF, limit);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      settings_used++;
   endtask

   function automatic link_event_type blank_beat(logic [2:0] op);
      link_event_type b;
      b = '0;
      b.opcode = op;
      b.now_ms = wall_ms;
      return b;
   endfunction

   function automatic link_event_type scrambled_beat(logic [2:0] op);
      link_event_type b;
      b = blank_beat(op);
      b.rx_ms = rand_time();
      b.recon = 1'($urandom_range(0, 1));
      b.settings_ok = 1'($urandom_range(0, 1));
      b.ready = 1'($urandom_range(0, 1));
      b.retryable = 1'($urandom_range(0, 1));
      b.after_ms = 19'($urandom);
      return b;
   endfunction

   task automatic send_start(bit settings_ok, bit ready, bit recon);
      link_event_type b;
      b = scrambled_beat(OP_START);
      b.settings_ok = settings_ok;
      b.ready = ready;
      b.recon = recon;
      drive_beat(b);
   endtask

   task automatic send_correction(logic [46:0] rx);
      link_event_type b;
      b = scrambled_beat(OP_CORRECTION);
      b.rx_ms = rx;
      last_rx = rx;
      drive_beat(b);
   endtask

   task automatic send_failure(bit retryable, logic [18:0] after);
      link_event_type b;
      b = scrambled_beat(OP_FAILURE);
      b.retryable = retryable;
      b.after_ms = after;
      drive_beat(b);
   endtask

   task automatic send_retry(bit ready);
      link_event_type b;
      b = scrambled_beat(OP_RETRY);
      b.ready = ready;
      drive_beat(b);
   endtask

   task automatic directed_sequence();
      wall_ms = 47'd100000;
      drive_beat(blank_beat(OP_RETRY));
      drive_beat(blank_beat(OP_SPARE_6));
      drive_beat(blank_beat(OP_SPARE_7));
      send_failure(1'b1, '0);
      send_start(1'b0, 1'b1, 1'b1);
      send_start(1'b1, 1'b0, 1'b1);
      send_start(1'b1, 1'b1, 1'b1);
      send_correction('0);
      send_correction(wall_ms + 47'd5);
      send_correction(wall_ms - 47'd5001);
      send_correction(wall_ms - 47'd5000);
      send_failure(1'b1, '0);
      send_retry(1'b0);
      send_start(1'b1, 1'b1, 1'b1);
      send_failure(1'b1, 19'h7FFFF);
      send_retry(1'b1);
      send_failure(1'b1, '0);
      drive_beat(blank_beat(OP_STOP));
      send_start(1'b1, 1'b1, 1'b0);
      send_failure(1'b1, '0);
      send_start(1'b1, 1'b1, 1'b1);
      send_failure(1'b0, '0);
      wall_ms = '1;
      send_start(1'b1, 1'b1, 1'b1);
      send_correction(wall_ms - 47'd1);
      drive_beat(blank_beat(OP_STOP));
      wall_ms = 47'd100000;
   endtask

   task automatic step_wall();
      int unsigned gap;
      gap = 32'(tracker.gap_ms);
      if (chance(85))
         wall_ms = wall_ms + $urandom_range(0, gap);
      else
         wall_ms = wall_ms + $urandom_range(gap, 3 * gap + 10);
   endtask

   task automatic random_correction();
      int unsigned gap;
      int unsigned sel;
      gap = 32'(tracker.gap_ms);
      sel = $urandom_range(0, 99);
      if (sel < 70)
         send_correction(wall_ms - $urandom_range(0, gap));
      else if (sel < 74)
         send_correction(wall_ms - gap);
      else if (sel < 80)
         send_correction(wall_ms - gap - $urandom_range(1, 50));
      else if (sel < 86)
         send_correction('0);
      else if (sel < 92)
         send_correction(wall_ms + $urandom_range(1, 2000));
      else
         send_correction(last_rx - $urandom_range(1, gap));
   endtask

   function automatic logic [18:0] random_after();
      if (chance(50))
         return '0;
      if (chance(60))
         return 19'($urandom_range(0, 300000));
      return 19'($urandom);
   endfunction

   task automatic run_sessions(int unsigned count);
      int unsigned target;
      int unsigned pick;
      bit          after_fail;
      target = beats_sent + count;
      while (beats_sent < target) begin
         if (chance(8)) begin
            wall_ms = rand_time();
            drive_beat(scrambled_beat(3'($urandom_range(0, 7))));
         end else begin
            if (chance(10))
               wall_ms = rand_time();
            send_start(chance(92), chance(90), chance(85));
            after_fail = 1'b0;
            repeat ($urandom_range(3, 30)) begin
               step_wall();
               pick = $urandom_range(0, 99);
               if (after_fail && chance(80)) begin
                  send_retry(chance(88));
                  after_fail = 1'b0;
               end else if (pick < 55) begin
                  random_correction();
               end else if (pick < 63) begin
                  drive_beat(scrambled_beat(OP_CONNECTED));
               end else if (pick < 80) begin
                  send_failure(chance(85), random_after());
                  after_fail = 1'b1;
               end else if (pick < 88) begin
                  send_retry(chance(88));
               end else if (pick < 92) begin
                  drive_beat(scrambled_beat(OP_STOP));
               end else if (pick < 96) begin
                  send_start(chance(92), chance(90), chance(85));
               end else begin
                  drive_beat(scrambled_beat(3'($urandom_range(0, 7))));
               end
            end
         end
      end
   endtask

   task automatic saturate_failures();
      send_start(1'b1, 1'b1, 1'b1);
      repeat (256) begin
         send_failure(1'b1, random_after());
         send_retry(1'b1);
      end
   endtask

   task automatic finish_run();
      int unsigned waited;
      @(negedge clock);
      req_valid = 1'b0;
      waited = 0;
      while (tracker.awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (tracker.awaited_results.size() != 0)
         report_mismatch($sformatf("%0d result beats never arrived",
                                   tracker.awaited_results.size()));
      $display("Checked %0d result beats for %0d event beats under %0d register settings.",
               tracker.checked, beats_sent, settings_used);
      $display("Seen %0d stream launches, %0d retry requests, %0d health-window clears.",
               tracker.launches, tracker.retry_requests, tracker.health_clears);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   endtask

   initial begin
      tracker = new();
      mismatches = 0;
      cycle_count = 0;
      beats_sent = 0;
      settings_used = 1;
      req_gap_pct = 30;
      rsp_stall_pct = 30;
      wall_ms = 47'd100000;
      last_rx = '0;
      req_valid = 1'b0;
      req_opcode = OP_STOP;
      req_now_ms = '0;
      req_received_at_ms = '0;
      req_reconnect_enable = 1'b0;
      req_settings_valid = 1'b0;
      req_stream_ready = 1'b0;
      req_retryable = 1'b0;
      req_retry_after_ms = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_sequence();
      run_sessions(300);
      apply_settings(1, 1, 1, 0, 0);
      run_sessions(200);
      apply_settings(600000, 3600000, 255, 40, 20);
      saturate_failures();
      run_sessions(100);
      apply_settings(2000, 6000, 0, 20, 50);
      run_sessions(150);
      apply_settings(32'h000F_FFFF, 32'h003F_FFFF, 3, 50, 10);
      run_sessions(200);
      apply_settings(5000, 20000, 6, 25, 25);
      run_sessions(200);
      apply_settings(300, 1200, 20, 10, 40);
      run_sessions(200);
      finish_run();
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lrs_pkg.sv
sv/lrs_session.sv
sv/link_reconnect_supervisor_top.sv
test/tb.sv
